[design/conv3x3_pkg.sv]
// ----------------------------------------------------------------------------
// conv3x3_pkg
// Widths, register indexes and controller states shared by the 3x3 filter.
// ----------------------------------------------------------------------------
`default_nettype none

package conv3x3_pkg;

  localparam int PIX_W      = 8;    // grey pixel width
  localparam int COEF_W     = 8;    // one signed coefficient
  localparam int CFG_IDX_W  = 3;    // register index width
  localparam int CFG_DATA_W = 24;   // widest register (coefficient rows)
  localparam int SIZE_CFG_W = 11;   // image_width / image_height registers
  localparam int DIV_W      = 8;    // divisor register
  localparam int BIAS_W     = 9;    // signed bias register
  localparam int TAPS       = 9;    // window positions
  localparam int PROD_W     = 17;   // signed 8 x signed 9
  localparam int SUM_W      = 20;   // nine products, signed
  localparam int MAG_W      = 19;   // magnitude of the weighted sum
  localparam int RES_W      = 21;   // signed quotient plus bias
  localparam int CNT_W      = 5;    // step counter for MAC and divide

  localparam int          SIZE_RESET     = 1024;
  localparam logic [23:0] COEF_MID_RESET = 24'h000100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_COEF_TOP     = 3'd2,
    REG_COEF_MID     = 3'd3,
    REG_COEF_BOTTOM  = 3'd4,
    REG_DIVISOR      = 3'd5,
    REG_BIAS         = 3'd6,
    REG_MAX_COLOR    = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_ABS,
    S_DIV,
    S_FIN
  } state_t;

  typedef logic [PIX_W-1:0] pix_t;

endpackage

`default_nettype wire

[design/conv3x3_in_if.sv]
// ----------------------------------------------------------------------------
// conv3x3_in_if
// Pixel stream channel: valid/ready with pixel value and flush mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface conv3x3_in_if import conv3x3_pkg::*; ();
  logic valid;
  logic ready;
  pix_t pixel_in;
  logic flush;

  modport source (output valid, output pixel_in, output flush, input ready);
  modport sink   (input valid, input pixel_in, input flush, output ready);
endinterface

`default_nettype wire

[design/conv3x3_out_if.sv]
// ----------------------------------------------------------------------------
// conv3x3_out_if
// Filtered pixel channel: valid/ready with pixel value and end-of-image mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface conv3x3_out_if import conv3x3_pkg::*; ();
  logic valid;
  logic ready;
  pix_t pixel_out;
  logic last_pixel;

  modport source (output valid, output pixel_out, output last_pixel, input ready);
  modport sink   (input valid, input pixel_out, input last_pixel, output ready);
endinterface

`default_nettype wire

[design/conv3x3_ram.sv]
// ----------------------------------------------------------------------------
// conv3x3_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module conv3x3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents when the same entry is written.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[design/conv3x3_image_filter.sv]
// ----------------------------------------------------------------------------
// conv3x3_image_filter
// 3x3 convolution over a raster grey stream with zero padding at the edges,
// divide by a programmable divisor, bias, and clamp to 0..max_color.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Payload                          Flow control
// pixels   in   pixel_in[7:0], flush             valid / ready
// results  out  pixel_out[7:0], last_pixel       valid / ready
// cfg      in   cfg_index[2:0], cfg_data[23:0]   cfg_write_en, always taken
//
// An item that produces no result is taken in S_IDLE, which stays ready. An
// item that produces a result runs through S_MAC, S_ABS, S_DIV and S_FIN
// before the next item is taken: nine taps in the single shared multiplier,
// the magnitude, then 19 quotient bits in the one-bit-per-cycle divider.
// Reset is synchronous. The line stores are not cleared: a row counter marks
// which store contents belong to the current image, so no clearing pass runs.
// A finished result waits in the output register; the block goes on taking
// items while it waits and stalls only when a second result is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module conv3x3_image_filter import conv3x3_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  conv3x3_in_if.sink            pixels,
  conv3x3_out_if.source         results
);

  // Column index addresses the line stores; the column counter compare needs
  // one more bit. The row counter runs up to height + 1 (the flush row).
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = AW + 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 2);
  localparam int W_RESET = (SIZE_RESET > MAX_WIDTH) ? MAX_WIDTH : SIZE_RESET;
  localparam int H_RESET = (SIZE_RESET > MAX_HEIGHT) ? MAX_HEIGHT : SIZE_RESET;

  // --------------------------------------------------------------------------
  // Configuration registers. Sizes and divisor are kept in their effective
  // (clamped) form so that the datapath never sees an illegal value.
  // --------------------------------------------------------------------------
  logic [WW-1:0]           w_eff;
  logic [HW-1:0]           h_eff;
  logic [CFG_DATA_W-1:0]   coef_top;
  logic [CFG_DATA_W-1:0]   coef_mid;
  logic [CFG_DATA_W-1:0]   coef_bottom;
  logic [DIV_W-1:0]        div_val;
  logic signed [BIAS_W-1:0] bias;
  logic [PIX_W-1:0]        max_color;

  logic [31:0]   size_raw;
  logic [WW-1:0] w_clamp;
  logic [HW-1:0] h_clamp;
  logic          size_clear;

  assign size_raw = 32'(cfg_data[SIZE_CFG_W-1:0]);

  always_comb begin
    if (size_raw == 32'd0) begin
      w_clamp = WW'(1);
    end else if (size_raw > 32'(MAX_WIDTH)) begin
      w_clamp = WW'(MAX_WIDTH);
    end else begin
      w_clamp = WW'(size_raw);
    end
    if (size_raw == 32'd0) begin
      h_clamp = HW'(1);
    end else if (size_raw > 32'(MAX_HEIGHT)) begin
      h_clamp = HW'(MAX_HEIGHT);
    end else begin
      h_clamp = HW'(size_raw);
    end
  end

  // A write to either size register abandons the image in progress.
  assign size_clear = cfg_write_en &&
                      (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      w_eff       <= WW'(W_RESET);
      h_eff       <= HW'(H_RESET);
      coef_top    <= '0;
      coef_mid    <= COEF_MID_RESET;
      coef_bottom <= '0;
      div_val     <= DIV_W'(1);
      bias        <= '0;
      max_color   <= '1;
    end else if (cfg_write_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  w_eff       <= w_clamp;
        REG_IMAGE_HEIGHT: h_eff       <= h_clamp;
        REG_COEF_TOP:     coef_top    <= cfg_data;
        REG_COEF_MID:     coef_mid    <= cfg_data;
        REG_COEF_BOTTOM:  coef_bottom <= cfg_data;
        REG_DIVISOR: begin
          // A zero divisor behaves as one.
          div_val <= (cfg_data[DIV_W-1:0] == '0) ? DIV_W'(1) : cfg_data[DIV_W-1:0];
        end
        REG_BIAS:         bias        <= $signed(cfg_data[BIAS_W-1:0]);
        REG_MAX_COLOR:    max_color   <= cfg_data[PIX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Controller state and handshake.
  // --------------------------------------------------------------------------
  state_t state;
  state_t state_next;

  logic accept;
  logic in_ready;
  logic load_out;
  logic out_free;
  logic [CNT_W-1:0] cnt;

  logic             out_valid;
  logic [PIX_W-1:0] out_pix;
  logic             out_last;

  assign accept   = pixels.valid && in_ready;
  assign out_free = !out_valid || results.ready;

  // --------------------------------------------------------------------------
  // Position counters and line stores.
  // --------------------------------------------------------------------------
  logic [AW-1:0] col;
  logic [AW-1:0] col_next;
  logic [RW-1:0] row;
  logic [RW-1:0] row_next;
  logic [CW-1:0] col_inc;
  logic          wrap;
  logic          emit;
  logic          last_item;

  pix_t pix;
  pix_t upper_q;
  pix_t lower_q;
  pix_t upper_val;
  pix_t lower_val;
  pix_t col_new [3];

  // Forwarding for the one-column image, where the entry just written is
  // read again in the same cycle.
  logic fwd;
  pix_t fwd_upper;
  pix_t fwd_lower;

  assign pix     = pixels.flush ? '0 : pixels.pixel_in;
  assign col_inc = CW'(col) + CW'(1);
  assign wrap    = col_inc >= CW'(w_eff);

  // Results start once the centre pixel has its full lower neighbor row.
  assign emit = (row >= RW'(2)) || (row == RW'(1) && col != '0);

  // The item at column 0 of row height + 1 delivers the final pixel.
  assign last_item = emit && (col == '0) && (row == RW'(h_eff) + RW'(1));

  always_comb begin
    col_next = col;
    row_next = row;
    if (rst || size_clear || (accept && last_item)) begin
      col_next = '0;
      row_next = '0;
    end else if (accept) begin
      col_next = wrap ? '0 : col_inc[AW-1:0];
      row_next = wrap ? row + RW'(1) : row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      fwd <= 1'b0;
    end else begin
      col <= col_next;
      row <= row_next;
      fwd <= accept && (col_next == col);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_upper <= lower_val;
      fwd_lower <= pix;
    end
  end

  // Store contents from an earlier image are hidden by the row count: the
  // lower store belongs to this image from row 1, the upper one from row 2.
  assign upper_val = (row < RW'(2)) ? '0 : (fwd ? fwd_upper : upper_q);
  assign lower_val = (row == '0)    ? '0 : (fwd ? fwd_lower : lower_q);

  assign col_new[0] = upper_val;
  assign col_new[1] = lower_val;
  assign col_new[2] = pix;

  // The read address always follows the next column, so the registered read
  // data belongs to the current column as soon as the position changes.
  conv3x3_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_upper_store (
    .clk   (clk),
    .we    (accept),
    .waddr (col),
    .wdata (lower_val),
    .raddr (col_next),
    .rdata (upper_q)
  );

  conv3x3_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_lower_store (
    .clk   (clk),
    .we    (accept),
    .waddr (col),
    .wdata (pix),
    .raddr (col_next),
    .rdata (lower_q)
  );

  // --------------------------------------------------------------------------
  // 3x3 window. Row 0 is the row above the centre, column 2 the newest.
  // --------------------------------------------------------------------------
  pix_t win [TAPS];
  pix_t tap_cur [TAPS];
  logic left_zero;
  logic right_zero;

  // At column 0 the centre is the last pixel of the previous row, so the
  // right column is outside the image; the left one is when the centre is
  // the first column.
  assign right_zero = (col == '0);
  assign left_zero  = (col == AW'(1)) || (col == '0 && w_eff == WW'(1));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tap_cur[3*i]     = left_zero  ? '0 : win[3*i+1];
      tap_cur[3*i + 1] = win[3*i+2];
      tap_cur[3*i + 2] = right_zero ? '0 : col_new[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || size_clear || (accept && last_item)) begin
      for (int k = 0; k < TAPS; k++) begin
        win[k] <= '0;
      end
    end else if (accept) begin
      for (int i = 0; i < 3; i++) begin
        win[3*i]     <= win[3*i+1];
        win[3*i + 1] <= win[3*i+2];
        win[3*i + 2] <= col_new[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Multiply-accumulate over the nine taps with one shared multiplier.
  // --------------------------------------------------------------------------
  logic signed [COEF_W-1:0] coef_all [TAPS];
  logic signed [COEF_W-1:0] coef_sh  [TAPS];
  pix_t                     tap_sh   [TAPS];
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  acc;
  logic signed [SUM_W-1:0]  mag_full;
  logic                     pend_last;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      coef_all[j]     = $signed(coef_top[COEF_W*j +: COEF_W]);
      coef_all[3 + j] = $signed(coef_mid[COEF_W*j +: COEF_W]);
      coef_all[6 + j] = $signed(coef_bottom[COEF_W*j +: COEF_W]);
    end
  end

  assign prod     = coef_sh[0] * $signed({1'b0, tap_sh[0]});
  assign mag_full = acc[SUM_W-1] ? -acc : acc;

  // --------------------------------------------------------------------------
  // Restoring divider, one quotient bit per cycle.
  // --------------------------------------------------------------------------
  logic             neg;
  logic [MAG_W-1:0] quo;
  logic [DIV_W-1:0] rem;
  logic [DIV_W:0]   trial;
  logic             trial_ok;

  assign trial    = {rem, quo[MAG_W-1]};
  assign trial_ok = trial >= {1'b0, div_val};

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept && emit) begin
          for (int k = 0; k < TAPS; k++) begin
            tap_sh[k]  <= tap_cur[k];
            coef_sh[k] <= coef_all[k];
          end
          acc       <= '0;
          pend_last <= last_item;
        end
      end
      S_MAC: begin
        acc <= acc + SUM_W'(prod);
        for (int k = 0; k < TAPS - 1; k++) begin
          tap_sh[k]  <= tap_sh[k+1];
          coef_sh[k] <= coef_sh[k+1];
        end
      end
      S_ABS: begin
        neg <= acc[SUM_W-1];
        quo <= mag_full[MAG_W-1:0];
        rem <= '0;
      end
      S_DIV: begin
        rem <= trial_ok ? DIV_W'(trial - {1'b0, div_val}) : trial[DIV_W-1:0];
        quo <= {quo[MAG_W-2:0], trial_ok};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (state == S_MAC || state == S_DIV) begin
      cnt <= (state_next == state) ? cnt + CNT_W'(1) : '0;
    end else begin
      cnt <= '0;
    end
  end

  // --------------------------------------------------------------------------
  // Sign, bias and clamp, then the output register.
  // --------------------------------------------------------------------------
  logic signed [RES_W-1:0] qs;
  logic signed [RES_W-1:0] val;
  logic [PIX_W-1:0]        clamped;

  always_comb begin
    qs  = neg ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
    val = qs + RES_W'(bias);
    if (val < 0) begin
      clamped = '0;
    end else if (val > $signed({{(RES_W - PIX_W){1'b0}}, max_color})) begin
      clamped = max_color;
    end else begin
      clamped = val[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_pix  <= clamped;
      out_last <= pend_last;
    end
  end

  assign results.valid      = out_valid;
  assign results.pixel_out  = out_pix;
  assign results.last_pixel = out_last;
  assign pixels.ready       = in_ready;

  // --------------------------------------------------------------------------
  // State machine.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept && emit) state_next = S_MAC;
      S_MAC:  if (cnt == CNT_W'(TAPS - 1)) state_next = S_ABS;
      S_ABS:  state_next = S_DIV;
      S_DIV:  if (cnt == CNT_W'(MAG_W - 1)) state_next = S_FIN;
      S_FIN:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    case (state)
      S_IDLE:  in_ready = 1'b1;
      S_FIN:   load_out = out_free;
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_col_in_row: assert property (@(posedge clk) disable iff (rst)
    CW'(col) < CW'(w_eff))
    else $error("column counter beyond image width");

  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    row <= RW'(h_eff) + RW'(1))
    else $error("row counter beyond flush row");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    accept && last_item && !size_clear |=> col == '0 && row == '0)
    else $error("position not cleared after final pixel");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> rem < div_val)
    else $error("divider remainder not below divisor");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    load_out |=> results.valid && state == S_IDLE)
    else $error("finished result not presented");
`endif

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 3x3 convolution filter. Small frames are
// streamed through the pixel channel with random gaps, the filtered stream
// is checked item by item against a predictor kept inside the bench, and
// the filter registers are changed between frames, including the clamped
// size extremes.
// ----------------------------------------------------------------------------

module tb;
  import conv3x3_pkg::*;

  localparam int LINE_DEPTH    = 1024;  // widest row the block handles
  localparam int MAX_ROWS      = 1024;  // tallest image the block handles
  localparam int RANDOM_ITEMS  = 1250;  // pixels in the random part
  localparam int DRAIN_CYCLES  = 40;    // result path plus margin
  localparam int HOLD_CYCLES   = 400;   // one long stall of the result side
  localparam int STALL_LIMIT   = 3000;  // cycles without any handshake
  localparam int REPORT_LIMIT  = 100;   // mismatch lines printed at most

  typedef struct packed {
    pix_t value;
    logic last;
  } filtered_px_t;

  // --------------------------------------------------------------------------
  // Predictor and result store. It keeps its own copy of the filter registers,
  // the two line stores, the window and the raster counters, and works out
  // the filtered pixel that each accepted item releases.
  // --------------------------------------------------------------------------
  class filtered_pixel_board;
    logic [10:0] width_reg;
    logic [10:0] height_reg;
    logic [23:0] coef_rows[3];      // top, centre, bottom
    logic [7:0]  div_reg;
    int          bias_val;
    logic [7:0]  max_reg;

    pix_t upper_line[LINE_DEPTH];
    pix_t lower_line[LINE_DEPTH];
    pix_t win[9];
    int   col_count;
    int   row_count;
    int   emitted;

    filtered_px_t awaited[$];
    int           errors;

    function new();
      width_reg    = 11'(SIZE_RESET);
      height_reg   = 11'(SIZE_RESET);
      coef_rows[0] = '0;
      coef_rows[1] = COEF_MID_RESET;
      coef_rows[2] = '0;
      div_reg      = 8'd1;
      bias_val     = 0;
      max_reg      = 8'd255;
      errors       = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      foreach (upper_line[i]) upper_line[i] = '0;
      foreach (lower_line[i]) lower_line[i] = '0;
      foreach (win[i]) win[i] = '0;
      col_count = 0;
      row_count = 0;
      emitted   = 0;
    endfunction

    function int clamp_dim(logic [10:0] v, int hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return int'(v);
    endfunction

    function void set_reg(cfg_reg_t idx, logic [23:0] data);
      case (idx)
        REG_IMAGE_WIDTH: begin
          width_reg = data[10:0];
          clear_frame();
        end
        REG_IMAGE_HEIGHT: begin
          height_reg = data[10:0];
          clear_frame();
        end
        REG_COEF_TOP:    coef_rows[0] = data;
        REG_COEF_MID:    coef_rows[1] = data;
        REG_COEF_BOTTOM: coef_rows[2] = data;
        REG_DIVISOR:     div_reg = data[7:0];
        REG_BIAS:        bias_val = int'($signed(data[8:0]));
        REG_MAX_COLOR:   max_reg = data[7:0];
        default: ;
      endcase
    endfunction

    function void take_pixel(pix_t value, logic is_flush);
      int           w, h, c, cc, sum;
      int           tap[3][3];
      pix_t         new_col[3];
      pix_t         px;
      bit           emit;
      filtered_px_t res;
      w    = clamp_dim(width_reg, LINE_DEPTH);
      h    = clamp_dim(height_reg, MAX_ROWS);
      c    = col_count;
      px   = is_flush ? pix_t'(0) : value;
      emit = (row_count >= 2) || (row_count == 1 && c >= 1);
      if (c >= w) c = 0;
      new_col[0] = upper_line[c];
      new_col[1] = lower_line[c];
      new_col[2] = px;

      // At the start of a row the centre is the last pixel of the row
      // before, so the window from before the shift is used.
      cc = 0;
      if (c == 0) begin
        for (int i = 0; i < 3; i++) begin
          tap[i][0] = win[i*3+1];
          tap[i][1] = win[i*3+2];
          tap[i][2] = 0;
        end
        cc = w - 1;
      end
      for (int i = 0; i < 3; i++) begin
        win[i*3]   = win[i*3+1];
        win[i*3+1] = win[i*3+2];
        win[i*3+2] = new_col[i];
      end
      if (c != 0) begin
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 3; j++)
            tap[i][j] = win[i*3+j];
        cc = c - 1;
      end
      // Zero padding at the left and right image edges.
      if (cc == 0)
        for (int i = 0; i < 3; i++) tap[i][0] = 0;
      if (cc == w - 1)
        for (int i = 0; i < 3; i++) tap[i][2] = 0;

      upper_line[c] = new_col[1];
      lower_line[c] = px;
      c++;
      if (c >= w) begin
        c = 0;
        row_count++;
      end
      col_count = c;
      if (!emit) return;

      sum = 0;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          sum += int'($signed(coef_rows[i][8*j +: 8])) * tap[i][j];
      sum = sum / ((div_reg == 0) ? 1 : int'(div_reg)) + bias_val;
      if (sum > int'(max_reg)) sum = int'(max_reg);
      if (sum < 0) sum = 0;
      emitted++;
      res.value = pix_t'(sum);
      res.last  = (emitted >= w * h);
      awaited.push_back(res);
      if (res.last) clear_frame();
    endfunction

    function void match_output(pix_t value, logic last);
      filtered_px_t want;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: unexpected output, expected none, actual pixel_out %0d last_pixel %0b",
                   $time, value, last);
        return;
      end
      want = awaited.pop_front();
      if (value !== want.value) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: pixel_out mismatch, expected %0d, actual %0d",
                   $time, want.value, value);
      end
      if (last !== want.last) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: last_pixel mismatch, expected %0b, actual %0b",
                   $time, want.last, last);
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block itself.
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst;
  logic                  cfg_write_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  conv3x3_in_if  pix_ch ();
  conv3x3_out_if res_ch ();

  always #4 clk = ~clk;

  conv3x3_image_filter uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixels       (pix_ch),
    .results      (res_ch)
  );

  filtered_pixel_board board;
  int item_count  = 0;    // pixel items accepted so far
  bit no_idle     = 1'b0; // when set, neither side inserts gaps
  bit hold_output = 1'b0; // asks the result side for one long stall
  int quiet_cycles = 0;

  // Gap lengths: most are zero or short, a few are long.
  function automatic int pick_gap();
    int roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 4);
    return $urandom_range(12, 60);
  endfunction

  // Pixel values lean toward the range ends so that clamping is exercised.
  function automatic pix_t rand_pixel();
    case ($urandom_range(0, 6))
      0:       return pix_t'(0);
      1:       return pix_t'(255);
      default: return pix_t'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] pick_coefs();
    logic [23:0] row;
    int          b;
    case ($urandom_range(0, 7))
      0: row = 24'h808080;
      1: row = 24'h7F7F7F;
      2: row = 24'h000000;
      3, 4, 5: begin
        // Small weights keep many sums inside the output range.
        for (int k = 0; k < 3; k++) begin
          b = $urandom_range(0, 8) - 4;
          row[8*k +: 8] = b[7:0];
        end
      end
      default: row = 24'($urandom);
    endcase
    return row;
  endfunction

  // A register write raises the enable with index and data, then drops it.
  task automatic write_reg(cfg_reg_t idx, logic [23:0] data);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= data;
    @(posedge clk);
    board.set_reg(idx, data);
    cfg_write_en <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one item after a random gap and wait until it is taken.
  task automatic push_pixel(pix_t value, logic is_flush);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_ch.valid    <= 1'b1;
    pix_ch.pixel_in <= value;
    pix_ch.flush    <= is_flush;
    do @(posedge clk); while (pix_ch.ready !== 1'b1);
    board.take_pixel(value, is_flush);
    item_count++;
  endtask

  // Bring the block to rest: no item offered, every expected result out,
  // then DRAIN_CYCLES more for an item that produces no result.
  task automatic settle();
    pix_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // A whole frame: the image in raster order, a few pixels possibly replaced
  // by flush items, then one row plus one of flush items for the bottom pad.
  task automatic send_frame(int cols, int rows, int flush_pct);
    for (int k = 0; k < cols * rows; k++)
      push_pixel(rand_pixel(), $urandom_range(0, 99) < flush_pct);
    for (int k = 0; k <= cols; k++)
      push_pixel(pix_t'($urandom), 1'b1);
  endtask

  task automatic randomize_filter();
    logic [8:0] bias_bits;
    write_reg(REG_COEF_TOP, pick_coefs());
    write_reg(REG_COEF_MID, pick_coefs());
    write_reg(REG_COEF_BOTTOM, pick_coefs());
    case ($urandom_range(0, 5))
      0:       write_reg(REG_DIVISOR, 24'd0);
      1:       write_reg(REG_DIVISOR, 24'd1);
      2:       write_reg(REG_DIVISOR, 24'd255);
      default: write_reg(REG_DIVISOR, 24'($urandom_range(1, 40)));
    endcase
    case ($urandom_range(0, 5))
      0:       bias_bits = 9'h100;   // -256
      1:       bias_bits = 9'h101;   // -255
      2:       bias_bits = 9'h0FF;   // +255
      default: bias_bits = 9'($urandom);
    endcase
    write_reg(REG_BIAS, 24'(bias_bits));
    case ($urandom_range(0, 5))
      0:       write_reg(REG_MAX_COLOR, 24'd0);
      1:       write_reg(REG_MAX_COLOR, 24'd1);
      2, 3:    write_reg(REG_MAX_COLOR, 24'd255);
      default: write_reg(REG_MAX_COLOR, 24'($urandom_range(1, 255)));
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Result side: ready is dropped for random stretches, and once for a long
  // hold while the pixel side keeps offering items, so the block backs up.
  // --------------------------------------------------------------------------
  initial begin
    int stall;
    res_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      stall = pick_gap();
      if (hold_output) begin
        stall       = HOLD_CYCLES;
        hold_output = 1'b0;
      end
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Every accepted output item is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready)
      board.match_output(res_ch.pixel_out, res_ch.last_pixel);
  end

  // The run is stopped if no item moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus.
  // --------------------------------------------------------------------------
  initial begin
    int  start_count, cols_reg, rows_reg, cols, rows, cut;
    bit  pressed;
    board           = new();
    rst             = 1'b1;
    cfg_write_en    = 1'b0;
    cfg_index       = REG_IMAGE_WIDTH;
    cfg_data        = '0;
    pix_ch.valid    = 1'b0;
    pix_ch.pixel_in = '0;
    pix_ch.flush    = 1'b0;
    pressed         = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. First a 3x2 frame with the filter at its reset
    // settings (identity), with one flush item standing in for a pixel
    // in the middle of the image.
    write_reg(REG_IMAGE_WIDTH, 24'd3);
    write_reg(REG_IMAGE_HEIGHT, 24'd2);
    push_pixel(8'd255, 1'b0);
    push_pixel(8'd0, 1'b0);
    push_pixel(8'hAA, 1'b1);
    push_pixel(8'd1, 1'b0);
    push_pixel(8'd254, 1'b0);
    push_pixel(8'd128, 1'b0);
    for (int k = 0; k < 4; k++) push_pixel(8'hFF, 1'b1);
    settle();

    // Sizes of zero are taken as one; largest positive weights, a zero
    // divisor and the most negative bias.
    write_reg(REG_IMAGE_WIDTH, 24'd0);
    write_reg(REG_IMAGE_HEIGHT, 24'd0);
    write_reg(REG_COEF_TOP, 24'h7F7F7F);
    write_reg(REG_COEF_MID, 24'h7F7F7F);
    write_reg(REG_COEF_BOTTOM, 24'h7F7F7F);
    write_reg(REG_DIVISOR, 24'd0);
    write_reg(REG_BIAS, 24'h000100);
    push_pixel(8'd255, 1'b0);
    push_pixel(8'd0, 1'b1);
    push_pixel(8'd0, 1'b1);
    settle();

    // Most negative weights, largest divisor, largest bias, clamp at one.
    write_reg(REG_IMAGE_WIDTH, 24'd2);
    write_reg(REG_IMAGE_HEIGHT, 24'd2);
    write_reg(REG_COEF_TOP, 24'h808080);
    write_reg(REG_COEF_MID, 24'h808080);
    write_reg(REG_COEF_BOTTOM, 24'h808080);
    write_reg(REG_DIVISOR, 24'd255);
    write_reg(REG_BIAS, 24'd255);
    write_reg(REG_MAX_COLOR, 24'd1);
    push_pixel(8'd255, 1'b0);
    push_pixel(8'd255, 1'b0);
    push_pixel(8'd0, 1'b0);
    push_pixel(8'd255, 1'b0);
    for (int k = 0; k < 3; k++) push_pixel(8'h00, 1'b1);
    settle();

    // A zero clamp, and an image cut short: its flush items never come and
    // a width write abandons it.
    write_reg(REG_MAX_COLOR, 24'd0);
    push_pixel(8'd200, 1'b0);
    push_pixel(8'd17, 1'b0);
    push_pixel(8'd99, 1'b0);
    settle();
    write_reg(REG_IMAGE_WIDTH, 24'd2);

    // Random part: mostly complete small frames with random content, some
    // cut off part way, and now and then new filter settings.
    randomize_filter();
    start_count = item_count;
    while (item_count - start_count < RANDOM_ITEMS) begin
      settle();
      if ($urandom_range(0, 3) == 0) randomize_filter();
      cols_reg = $urandom_range(0, 8);
      rows_reg = $urandom_range(0, 6);
      cols     = (cols_reg == 0) ? 1 : cols_reg;
      rows     = (rows_reg == 0) ? 1 : rows_reg;
      write_reg(REG_IMAGE_WIDTH, 24'(cols_reg));
      write_reg(REG_IMAGE_HEIGHT, 24'(rows_reg));
      no_idle = ($urandom_range(0, 4) == 0);
      if (!pressed && item_count - start_count > RANDOM_ITEMS / 2) begin
        // The long output hold lands on a complete frame with many results.
        pressed     = 1'b1;
        no_idle     = 1'b0;
        hold_output = 1'b1;
        send_frame(cols, rows, 5);
      end else if ($urandom_range(0, 6) == 0) begin
        cut = $urandom_range(1, cols * rows + cols);
        for (int k = 0; k < cut; k++)
          push_pixel(rand_pixel(), $urandom_range(0, 3) == 0);
      end else begin
        send_frame(cols, rows, 5);
      end
      no_idle = 1'b0;
    end

    // Size extremes: a width above the limit is clamped to the widest row,
    // and a height above the limit to the tallest image.
    settle();
    randomize_filter();
    write_reg(REG_IMAGE_WIDTH, 24'd2047);
    write_reg(REG_IMAGE_HEIGHT, 24'd1);
    send_frame(LINE_DEPTH, 1, 2);
    settle();
    write_reg(REG_IMAGE_WIDTH, 24'd1);
    write_reg(REG_IMAGE_HEIGHT, 24'd2000);
    send_frame(1, MAX_ROWS, 2);
    settle();

    if (board.errors == 0 && board.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
design/conv3x3_pkg.sv
design/conv3x3_in_if.sv
design/conv3x3_out_if.sv
design/conv3x3_ram.sv
design/conv3x3_image_filter.sv
tb/tb.sv
